// ===== rtl/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
`default_nettype none

package ple_pkg;

  // Fixed field widths
  localparam int unsigned OpW       = 3;
  localparam int unsigned PosW      = 5;
  localparam int unsigned DataW     = 32;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned CountOutW = 5;

  // Default number of list entries
  localparam int unsigned DefaultDepth = 16;

  // Operation codes
  typedef enum logic [OpW-1:0] {
    OP_APPEND_END   = 3'd0,
    OP_REMOVE_END   = 3'd1,
    OP_INSERT_FRONT = 3'd2,
    OP_REMOVE_FRONT = 3'd3,
    OP_INSERT_AT    = 3'd4,
    OP_REMOVE_AT    = 3'd5,
    OP_READ_AT      = 3'd6
  } op_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Controller to datapath command
  typedef struct packed {
    logic execute;  // perform the operation on the word at the input ports
    logic hold;     // result register is waiting to be taken
  } ple_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/ple_ctrl.sv =====
// Controller: handshake sequencing for the positional list engine.
`default_nettype none

module ple_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire             out_stall_i,
  output ple_pkg::ple_cmd_t cmd_o
);
  import ple_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RESP = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Handshake and commands
  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = (state_q == S_RESP);
  assign cmd_o.execute = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.hold    = (state_q == S_RESP);

endmodule

`default_nettype wire

// ===== rtl/ple_datapath.sv =====
// Datapath: row of element cells, count register and result register.
`default_nettype none

module ple_datapath #(
  parameter int unsigned DEPTH = ple_pkg::DefaultDepth
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  ple_pkg::ple_cmd_t                     cmd_i,
  input  wire        [ple_pkg::OpW-1:0]         op_i,
  input  wire        [ple_pkg::PosW-1:0]        position_i,
  input  wire signed [ple_pkg::DataW-1:0]       value_i,
  output logic       [ple_pkg::StatusW-1:0]     status_o,
  output logic       [ple_pkg::CountOutW-1:0]   count_o,
  output logic signed [ple_pkg::DataW-1:0]      data_o
);
  import ple_pkg::*;

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CMPW = (CW > PosW) ? CW : PosW;

  logic [DataW-1:0] elems_q [DEPTH];
  logic [DataW-1:0] elems_d [DEPTH];
  logic [CW-1:0]    count_q, count_d;

  logic [StatusW-1:0]   status_q, status_d;
  logic [CountOutW-1:0] count_out_q;
  logic [DataW-1:0]     data_q, data_d;

  logic            full, empty;
  logic [CMPW-1:0] cnt_w, pos_w, at_w;
  logic [IW-1:0]   at_idx;
  logic            do_ins, do_rem;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);
  assign cnt_w = CMPW'(count_q);
  assign pos_w = CMPW'(position_i);

  // Decode: target index, status and which way the cells move
  always_comb begin
    at_w     = '0;
    status_d = ST_OK;
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    case (op_e'(op_i))
      OP_APPEND_END, OP_INSERT_FRONT, OP_INSERT_AT: begin
        if (op_e'(op_i) == OP_APPEND_END) at_w = cnt_w;
        else if (op_e'(op_i) == OP_INSERT_AT) at_w = pos_w;
        if (full) status_d = ST_FULL;
        else if (at_w > cnt_w) status_d = ST_RANGE;
        else do_ins = 1'b1;
      end
      OP_REMOVE_END, OP_REMOVE_FRONT, OP_REMOVE_AT, OP_READ_AT: begin
        if (op_e'(op_i) == OP_REMOVE_END) at_w = cnt_w - CMPW'(1);
        else if (op_e'(op_i) != OP_REMOVE_FRONT) at_w = pos_w;
        if (empty) status_d = ST_EMPTY;
        else if (at_w >= cnt_w) status_d = ST_RANGE;
        else if (op_e'(op_i) != OP_READ_AT) do_rem = 1'b1;
      end
      default: ;
    endcase
  end

  assign at_idx = at_w[IW-1:0];

  // Removed or read word; zero unless a remove or read succeeded
  always_comb begin
    data_d = '0;
    if (status_d == ST_OK &&
        (op_i inside {OP_REMOVE_END, OP_REMOVE_FRONT, OP_REMOVE_AT, OP_READ_AT})) begin
      data_d = elems_q[at_idx];
    end
  end

  // Count update
  always_comb begin
    count_d = count_q;
    if (do_ins) count_d = count_q + CW'(1);
    else if (do_rem) count_d = count_q - CW'(1);
  end

  // Cell row: each cell takes its lower neighbour, its upper neighbour or the new word
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    always_comb begin
      elems_d[g] = elems_q[g];
      if (do_ins) begin
        if (IW'(g) == at_idx) begin
          elems_d[g] = value_i;
        end else if (IW'(g) > at_idx) begin
          if (g > 0) elems_d[g] = elems_q[(g > 0) ? g - 1 : 0];
        end
      end else if (do_rem) begin
        if (IW'(g) >= at_idx && g < DEPTH - 1) begin
          elems_d[g] = elems_q[(g < DEPTH - 1) ? g + 1 : g];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.execute) elems_q[g] <= elems_d[g];
    end
  end

  // List count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
    end
  end

  // Result register, held while the word waits to be taken
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && !cmd_i.hold) begin
      status_q    <= status_d;
      count_out_q <= CountOutW'(count_d);
      data_q      <= data_d;
    end
  end

  assign status_o = status_q;
  assign count_o  = count_out_q;
  assign data_o   = data_q;

endmodule

`default_nettype wire

// ===== rtl/positional_list_engine_top.sv =====
// Top level of the positional list engine: controller plus datapath.
//
//  channel  | handshake                  | fields
//  ---------+----------------------------+------------------------------
//  in       | in_valid_i / in_stall_o    | op_i, position_i, value_i
//  out      | out_valid_o / out_stall_i  | status_o, count_o, data_o
//
// An operation runs in the cycle its word is accepted,
// with every cell of the row shifting at once, and its result is shown from
// the next cycle. One word is in flight at a time; the input stalls until the
// result is taken, so a stalled output holds the whole engine.
// Reset clears the count to an empty list; element cells are not reset.
`default_nettype none

module positional_list_engine_top #(
  parameter int unsigned DEPTH = ple_pkg::DefaultDepth
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire        [ple_pkg::OpW-1:0]       op_i,
  input  wire        [ple_pkg::PosW-1:0]      position_i,
  input  wire signed [ple_pkg::DataW-1:0]     value_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic       [ple_pkg::StatusW-1:0]   status_o,
  output logic       [ple_pkg::CountOutW-1:0] count_o,
  output logic signed [ple_pkg::DataW-1:0]    data_o
);
  import ple_pkg::*;

  ple_cmd_t cmd;

  // Handshake sequencing
  ple_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // List storage and operation logic
  ple_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .op_i       (op_i),
    .position_i (position_i),
    .value_i    (value_i),
    .status_o   (status_o),
    .count_o    (count_o),
    .data_o     (data_o)
  );

endmodule

`default_nettype wire
